// File: rtl/qbc_pkg.sv
// shared constants and types of the q-binomial coefficient generator
package qbc_pkg;

	localparam int MAX_N_DEF = 15;   // largest supported n
	localparam int ARG_W     = 4;    // width of n and k
	localparam int COEF_W    = 13;   // coefficient width, sums wrap
	localparam int EXP_W     = 6;    // exponent port width

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ROW,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} state_t;

	// sequencer to output register
	typedef struct packed {
		logic             load;
		logic             zero;
		logic             last;
		logic [EXP_W-1:0] exponent;
	} emit_t;

endpackage

// File: rtl/qbc_store.sv
// coefficient scratch store: one write port, two registered read ports
module qbc_store #(
	parameter int MAX_N = qbc_pkg::MAX_N_DEF,
	localparam int DEG_MAX = (MAX_N / 2) * ((MAX_N + 1) / 2),
	localparam int ROW_LEN = DEG_MAX + 1,
	localparam int DEPTH = (MAX_N + 1) * ROW_LEN,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr_a,
	input  logic [AW-1:0]             rd_addr_b,
	output logic [qbc_pkg::COEF_W-1:0] rd_data_a,
	output logic [qbc_pkg::COEF_W-1:0] rd_data_b,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [qbc_pkg::COEF_W-1:0] wr_data
);

	logic [qbc_pkg::COEF_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// File: rtl/qbc_ctrl.sv
// sequencer: row clear, q-pascal row updates through one adder, coefficient readout
module qbc_ctrl #(
	parameter int MAX_N = qbc_pkg::MAX_N_DEF,
	localparam int DEG_MAX = (MAX_N / 2) * ((MAX_N + 1) / 2),
	localparam int ROW_LEN = DEG_MAX + 1,
	localparam int DEPTH = (MAX_N + 1) * ROW_LEN,
	localparam int AW = $clog2(DEPTH),
	localparam int EW = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_take,
	input  logic [qbc_pkg::ARG_W-1:0]  n_in,
	input  logic [qbc_pkg::ARG_W-1:0]  k_in,
	input  logic                       out_taken,
	input  logic [qbc_pkg::COEF_W-1:0] rd_data_a,
	input  logic [qbc_pkg::COEF_W-1:0] rd_data_b,
	output logic                       busy,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr_a,
	output logic [AW-1:0]              rd_addr_b,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [qbc_pkg::COEF_W-1:0] wr_data,
	output qbc_pkg::emit_t             emit
);

	localparam int PW = 2 * qbc_pkg::ARG_W;

	qbc_pkg::state_t state_q, state_d;
	logic [qbc_pkg::ARG_W-1:0] n_q, n_d, k_q, k_d, i_q, i_d, j_q, j_d;
	logic [EW-1:0] e_q, e_d, deg_q, deg_d;
	logic [AW-1:0] clr_q, clr_d, clr_end_q, clr_end_d;
	logic zero_q, zero_d, last_q, last_d;
	logic wr_en_s1, wr_en_s1_d;
	logic [AW-1:0] wr_addr_s1;

	logic [qbc_pkg::ARG_W-1:0] row_sel, j_dec, sh, i_inc;
	logic [EW-1:0] src_e;
	logic [PW-1:0] prod;
	logic emit_last;

	// address generation, each row base by constant multiply
	always_comb begin
		row_sel   = (state_q == qbc_pkg::ST_ROW) ? j_q : k_q;
		j_dec     = j_q - qbc_pkg::ARG_W'(1);
		sh        = i_q - j_q;
		src_e     = e_q - EW'(sh);
		i_inc     = i_q + qbc_pkg::ARG_W'(1);
		rd_addr_a = AW'(row_sel) * AW'(ROW_LEN) + AW'(e_q);
		rd_addr_b = AW'(j_dec) * AW'(ROW_LEN) + AW'(src_e);
		prod      = PW'(k_in) * PW'(n_in - k_in);
		emit_last = zero_q || (e_q == deg_q);
	end

	// write port: clear sweep, else the adder write-back
	always_comb begin
		if (state_q == qbc_pkg::ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = (clr_q == '0) ? qbc_pkg::COEF_W'(1) : '0;
		end else begin
			wr_en   = wr_en_s1;
			wr_addr = wr_addr_s1;
			wr_data = rd_data_a + rd_data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= qbc_pkg::ST_IDLE;
			n_q       <= '0;
			k_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			e_q       <= '0;
			deg_q     <= '0;
			clr_q     <= '0;
			clr_end_q <= '0;
			zero_q    <= 1'b0;
			last_q    <= 1'b0;
			wr_en_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			n_q       <= n_d;
			k_q       <= k_d;
			i_q       <= i_d;
			j_q       <= j_d;
			e_q       <= e_d;
			deg_q     <= deg_d;
			clr_q     <= clr_d;
			clr_end_q <= clr_end_d;
			zero_q    <= zero_d;
			last_q    <= last_d;
			wr_en_s1  <= wr_en_s1_d;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= rd_addr_a;
	end

	always_comb begin
		state_d    = state_q;
		n_d        = n_q;
		k_d        = k_q;
		i_d        = i_q;
		j_d        = j_q;
		e_d        = e_q;
		deg_d      = deg_q;
		clr_d      = clr_q;
		clr_end_d  = clr_end_q;
		zero_d     = zero_q;
		last_d     = last_q;
		wr_en_s1_d = 1'b0;
		rd_en      = 1'b0;
		emit.load     = 1'b0;
		emit.zero     = zero_q;
		emit.last     = emit_last;
		emit.exponent = qbc_pkg::EXP_W'(e_q);
		case (state_q)
			qbc_pkg::ST_IDLE: begin
				if (in_take) begin
					n_d       = n_in;
					k_d       = k_in;
					e_d       = '0;
					clr_d     = '0;
					clr_end_d = AW'(AW'(k_in) + AW'(1)) * AW'(ROW_LEN) - AW'(1);
					deg_d     = (32'(prod) > DEG_MAX) ? EW'(DEG_MAX) : EW'(prod);
					if (32'(n_in) > MAX_N || k_in > n_in) begin
						zero_d  = 1'b1;
						state_d = qbc_pkg::ST_EMIT_LD;
					end else begin
						zero_d  = 1'b0;
						state_d = qbc_pkg::ST_CLEAR;
					end
				end
			end
			qbc_pkg::ST_CLEAR: begin
				if (clr_q == clr_end_q) begin
					if (k_q == '0) begin
						e_d     = '0;
						state_d = qbc_pkg::ST_EMIT_RD;
					end else begin
						i_d     = qbc_pkg::ARG_W'(1);
						j_d     = qbc_pkg::ARG_W'(1);
						e_d     = EW'(DEG_MAX);
						state_d = qbc_pkg::ST_ROW;
					end
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			qbc_pkg::ST_ROW: begin
				rd_en      = 1'b1;
				wr_en_s1_d = 1'b1;
				if (e_q == EW'(sh)) begin
					state_d = qbc_pkg::ST_DRAIN;
				end else begin
					e_d = e_q - EW'(1);
				end
			end
			qbc_pkg::ST_DRAIN: begin
				if (j_q > qbc_pkg::ARG_W'(1)) begin
					j_d     = j_dec;
					e_d     = EW'(DEG_MAX);
					state_d = qbc_pkg::ST_ROW;
				end else if (i_q < n_q) begin
					i_d     = i_inc;
					j_d     = (i_inc < k_q) ? i_inc : k_q;
					e_d     = EW'(DEG_MAX);
					state_d = qbc_pkg::ST_ROW;
				end else begin
					e_d     = '0;
					state_d = qbc_pkg::ST_EMIT_RD;
				end
			end
			qbc_pkg::ST_EMIT_RD: begin
				rd_en   = 1'b1;
				state_d = qbc_pkg::ST_EMIT_LD;
			end
			qbc_pkg::ST_EMIT_LD: begin
				emit.load = 1'b1;
				last_d    = emit_last;
				state_d   = qbc_pkg::ST_EMIT_WAIT;
			end
			qbc_pkg::ST_EMIT_WAIT: begin
				if (out_taken) begin
					if (last_q) begin
						state_d = qbc_pkg::ST_IDLE;
					end else begin
						e_d     = e_q + EW'(1);
						state_d = qbc_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = qbc_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != qbc_pkg::ST_IDLE);

endmodule

// File: rtl/q_binomial_coefficients.sv
// q-binomial coefficient generator, top level
// operation: clears rows 0..k, then runs one read-add-write pass per row (i,j) of the
//   recurrence, then reads out each coefficient, waiting while the output is stalled
// throughput: one query at a time, bounded by the single adder and the single write port
//   of the coefficient store
// reset: arst_n asynchronous active low clears the sequencer and output valid; the store is not
//   cleared, each query wipes the rows it uses
module q_binomial_coefficients #(
	parameter int MAX_N = qbc_pkg::MAX_N_DEF,
	localparam int DEG_MAX = (MAX_N / 2) * ((MAX_N + 1) / 2),
	localparam int ROW_LEN = DEG_MAX + 1,
	localparam int DEPTH = (MAX_N + 1) * ROW_LEN,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [qbc_pkg::ARG_W-1:0]  n_upper,
	input  logic [qbc_pkg::ARG_W-1:0]  k_lower,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [qbc_pkg::EXP_W-1:0]  exponent,
	output logic [qbc_pkg::COEF_W-1:0] coefficient,
	output logic                       last_coefficient,
	output logic                       valid_range
);

	logic in_take, out_taken, busy;
	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
	logic [qbc_pkg::COEF_W-1:0] rd_data_a, rd_data_b, wr_data;
	qbc_pkg::emit_t emit;
	logic out_valid_q;

	// a new query word is taken only when the whole previous polynomial has left
	assign in_stall  = busy;
	assign in_take   = in_valid && !in_stall;
	assign out_taken = out_valid_q && !out_stall;

	// sequencer: clears rows 0..k (row 0 gets the constant 1), then for each i
	// updates rows min(i,k) down to 1 in place, dst[e] += src[e-(i-j)], through
	// one read-add-write pipeline; then reads row k out one coefficient at a time
	qbc_ctrl #(
		.MAX_N(MAX_N)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.n_in      (n_upper),
		.k_in      (k_lower),
		.out_taken (out_taken),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.emit      (emit)
	);

	// (MAX_N+1) rows of ROW_LEN coefficients
	qbc_store #(
		.MAX_N(MAX_N)
	) u_store (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// output word register, held while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (out_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	// zero polynomial for k above n or n out of range: coefficient 0, range flag low
	always_ff @(posedge clk) begin
		if (emit.load) begin
			exponent         <= emit.exponent;
			coefficient      <= emit.zero ? '0 : rd_data_a;
			last_coefficient <= emit.last;
			valid_range      <= !emit.zero;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/qbc_check.sv
// port-level checks of the q-binomial generator and their bind
module qbc_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [qbc_pkg::EXP_W-1:0]  exponent,
	input logic [qbc_pkg::COEF_W-1:0] coefficient,
	input logic                       last_coefficient,
	input logic                       valid_range
);

	// a pending result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// no query is taken while a result word is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("query accepted with result pending");

	// an accepted query keeps the block busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("not busy after query");

	// out-of-range query gives one zero word
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_range |-> last_coefficient && coefficient == '0 && exponent == '0)
		else $error("bad zero-polynomial word");

endmodule

bind q_binomial_coefficients qbc_check u_qbc_check (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.exponent         (exponent),
	.coefficient      (coefficient),
	.last_coefficient (last_coefficient),
	.valid_range      (valid_range)
);

// File: tb/sv/q_binomial_coefficients_tb.sv
// testbench of the q-binomial coefficient generator: random and directed queries, checked per word
`timescale 1ns / 100ps

module q_binomial_coefficients_tb;

	// sizes seen by the block at its default parameter
	localparam int MAXN     = qbc_pkg::MAX_N_DEF;
	localparam int DEG      = (MAXN / 2) * ((MAXN + 1) / 2);
	localparam int N_RANDOM = 120;
	// the slowest query runs the full recurrence, or emits 57 words with a long stall on
	// each; about 140 queries in all, and this limit is several times that slowest run
	localparam int CYCLE_LIMIT = 6_000_000;
	// quiet period once nothing is due, beyond the output pipeline
	localparam int TAIL_CYCLES = 100;
	localparam int MAX_PRINTED = 30;

	// one query word as queued for the driver
	typedef struct {
		logic [qbc_pkg::ARG_W-1:0] n;
		logic [qbc_pkg::ARG_W-1:0] k;
		bit                        drain_first;  // hold off until every due coefficient is back
	} query_t;

	// one coefficient word as it should leave the block
	typedef struct packed {
		logic [qbc_pkg::EXP_W-1:0]  exponent;
		logic [qbc_pkg::COEF_W-1:0] coefficient;
		logic                       last;
		logic                       range_ok;
	} coef_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [qbc_pkg::ARG_W-1:0]  n_upper = '0;
	logic [qbc_pkg::ARG_W-1:0]  k_lower = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [qbc_pkg::EXP_W-1:0]  exponent;
	logic [qbc_pkg::COEF_W-1:0] coefficient;
	logic                       last_coefficient;
	logic                       valid_range;

	query_t     query_backlog[$];
	coef_word_t coef_due[$];
	int         fail_count = 0;
	int         cycle_count = 0;
	int         in_gap = 0;
	int         out_hold = 0;

	q_binomial_coefficients dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.n_upper          (n_upper),
		.k_lower          (k_lower),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.exponent         (exponent),
		.coefficient      (coefficient),
		.last_coefficient (last_coefficient),
		.valid_range      (valid_range)
	);

	initial forever #5 clk = ~clk;

	// one line per mismatch, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("%0t ERROR %s", $time, what);
	endtask

	// idle length: mostly none or short, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// build [n choose k]_q with the q-pascal rule, each row updated in place with j going
	// down, and queue its coefficients from exponent 0 to k(n-k)
	function automatic void predict_q_binomial(input logic [qbc_pkg::ARG_W-1:0] n,
			input logic [qbc_pkg::ARG_W-1:0] k);
		logic [qbc_pkg::COEF_W-1:0] rows [0:MAXN][0:DEG];
		coef_word_t                 w;
		int                         ni;
		int                         ki;
		int                         top;
		int                         deg;
		ni = int'(n);
		ki = int'(k);
		// k above n (or n beyond the table): the zero polynomial as one word
		if (ni > MAXN || ki > ni) begin
			w.exponent    = '0;
			w.coefficient = '0;
			w.last        = 1'b1;
			w.range_ok    = 1'b0;
			coef_due.push_back(w);
			return;
		end
		for (int j = 0; j <= MAXN; j++)
			for (int e = 0; e <= DEG; e++)
				rows[j][e] = '0;
		rows[0][0] = qbc_pkg::COEF_W'(1);
		for (int i = 1; i <= ni; i++) begin
			top = (i < ki) ? i : ki;
			for (int j = top; j >= 1; j--) begin
				if (j == i) begin
					// diagonal entry is the constant 1
					for (int e = 0; e <= DEG; e++)
						rows[j][e] = '0;
					rows[j][0] = qbc_pkg::COEF_W'(1);
				end else begin
					// add q^(i-j) times the row below, sums wrap at the coefficient width
					for (int e = DEG; e >= i - j; e--)
						rows[j][e] = rows[j][e] + rows[j - 1][e - (i - j)];
				end
			end
		end
		deg = ki * (ni - ki);
		if (deg > DEG)
			deg = DEG;
		for (int e = 0; e <= deg; e++) begin
			w.exponent    = e[qbc_pkg::EXP_W-1:0];
			w.coefficient = rows[ki][e];
			w.last        = (e == deg);
			w.range_ok    = 1'b1;
			coef_due.push_back(w);
		end
	endfunction

	function automatic void add_query(input int n, input int k, input bit drain_first);
		query_t q;
		q.n           = n[qbc_pkg::ARG_W-1:0];
		q.k           = k[qbc_pkg::ARG_W-1:0];
		q.drain_first = drain_first;
		query_backlog.push_back(q);
	endfunction

	// query driver: holds a stalled word, idles at random, and waits for the output side
	// to drain before any query marked for it
	always @(posedge clk or negedge arst_n) begin : drive_queries
		query_t q;
		bit     can_issue;
		if (!arst_n) begin
			in_valid <= 1'b0;
			n_upper  <= '0;
			k_lower  <= '0;
			in_gap   <= 0;
		end else begin
			// a word taken at this edge: its coefficients become due
			if (in_valid && !in_stall)
				predict_q_binomial(n_upper, k_lower);
			// a stalled word stays as it is
			if (!(in_valid && in_stall)) begin
				can_issue = query_backlog.size() != 0;
				if (can_issue && query_backlog[0].drain_first && coef_due.size() != 0)
					can_issue = 1'b0;
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (can_issue) begin
					q = query_backlog.pop_front();
					in_valid <= 1'b1;
					n_upper  <= q.n;
					k_lower  <= q.k;
					in_gap   <= idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// coefficient monitor and output stall: every taken word is checked field by field
	// against the oldest due word; stalls pause in quiet windows to leave clean stretches
	always @(posedge clk or negedge arst_n) begin : watch_coefficients
		coef_word_t w;
		int         len;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (coef_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word exponent %0d coefficient %0d",
						exponent, coefficient));
				end else begin
					w = coef_due.pop_front();
					if (exponent !== w.exponent)
						report_mismatch($sformatf("exponent got %0d want %0d",
							exponent, w.exponent));
					if (coefficient !== w.coefficient)
						report_mismatch($sformatf("coefficient at q^%0d got %0d want %0d",
							w.exponent, coefficient, w.coefficient));
					if (last_coefficient !== w.last)
						report_mismatch($sformatf("last_coefficient at q^%0d got %b want %b",
							w.exponent, last_coefficient, w.last));
					if (valid_range !== w.range_ok)
						report_mismatch($sformatf("valid_range at q^%0d got %b want %b",
							w.exponent, valid_range, w.range_ok));
				end
			end
			if (out_hold != 0) begin
				out_stall <= 1'b1;
				out_hold  <= out_hold - 1;
			end else begin
				len = idle_len();
				// no new stall starts in one window of four
				if (cycle_count[12:11] != 2'd0 && len != 0 && $urandom_range(0, 2) == 0) begin
					out_stall <= 1'b1;
					out_hold  <= len - 1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		int k;
		// directed: corners of both fields, k zero, k equal to n, k above n, widest rows
		add_query(0, 0, 1'b0);
		add_query(15, 0, 1'b0);
		add_query(15, 15, 1'b0);
		add_query(15, 7, 1'b0);
		add_query(15, 8, 1'b1);    // sent only once everything before it has drained
		add_query(0, 15, 1'b0);
		add_query(3, 5, 1'b0);
		add_query(14, 15, 1'b0);
		add_query(1, 0, 1'b0);
		add_query(1, 1, 1'b0);
		add_query(2, 1, 1'b0);
		add_query(4, 2, 1'b0);
		add_query(5, 2, 1'b0);
		add_query(6, 3, 1'b0);
		add_query(15, 1, 1'b0);
		add_query(15, 14, 1'b0);
		add_query(14, 7, 1'b0);
		add_query(10, 10, 1'b0);
		add_query(0, 1, 1'b0);
		add_query(12, 6, 1'b0);
		// random: mostly small n to keep the run short, some full width, some k above n
		for (int t = 0; t < N_RANDOM; t++) begin
			if ($urandom_range(0, 99) < 75)
				n = $urandom_range(0, 10);
			else
				n = $urandom_range(11, 15);
			if ($urandom_range(0, 99) < 15 && n < 15)
				k = $urandom_range(n + 1, 15);
			else
				k = $urandom_range(0, n);
			add_query(n, k, $urandom_range(0, 99) < 4);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// all queries taken, then all coefficients back, then a quiet tail
		while (query_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (coef_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: q_binomial_coefficients.f
rtl/qbc_pkg.sv
rtl/qbc_store.sv
rtl/qbc_ctrl.sv
rtl/q_binomial_coefficients.sv
rtl/qbc_check.sv
tb/sv/q_binomial_coefficients_tb.sv
